/* design/tlx_pkg.sv */
// Shared types, constants and byte-class functions for the text lexer.
// Used by tlx_core, tlx_queue and text_lexer; depends on nothing else.
package tlx_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LEN_BITS      = 16;
    localparam int FIELD_BITS    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = QPTR_BITS + 1;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Byte codes the lexer looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR,
        MODE_STR,
        MODE_ESC,
        MODE_IDENT,
        MODE_NUM
    } mode_t;

    typedef enum logic [3:0] {
        TOK_EOF,
        TOK_LPAREN,
        TOK_RPAREN,
        TOK_LBRACE,
        TOK_RBRACE,
        TOK_LBRACK,
        TOK_RBRACK,
        TOK_COLON,
        TOK_SEMI,
        TOK_STAR,
        TOK_EQUAL,
        TOK_STRING,
        TOK_IDENT,
        TOK_NUMBER,
        TOK_UNKNOWN
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t              kind;
        logic [FIELD_BITS-1:0]  start;
        logic [FIELD_BITS-1:0]  length;
        logic                   last;
    } token_t;

    // Tokens produced by one accepted byte, in emission order
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] level;
    } q_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE) || (c == CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
    endfunction

    // One-byte symbol kind; TOK_EOF means the byte is no symbol
    function automatic tok_kind_t symbol_kind(input logic [7:0] c);
        tok_kind_t k;
        case (c)
            CH_LPAREN: k = TOK_LPAREN;
            CH_RPAREN: k = TOK_RPAREN;
            CH_LBRACE: k = TOK_LBRACE;
            CH_RBRACE: k = TOK_RBRACE;
            CH_LBRACK: k = TOK_LBRACK;
            CH_RBRACK: k = TOK_RBRACK;
            CH_COLON:  k = TOK_COLON;
            CH_SEMI:   k = TOK_SEMI;
            CH_STAR:   k = TOK_STAR;
            CH_EQUAL:  k = TOK_EQUAL;
            default:   k = TOK_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] x);
        return (x == LEN_MAX) ? x : x + LEN_BITS'(1);
    endfunction

endpackage

/* design/tlx_queue.sv */
// Result queue for the text lexer: takes up to two tokens per cycle, gives one.
// Depends on tlx_pkg.
module tlx_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_en,
    input  tlx_pkg::push_t  push,
    input  logic            pop,
    output tlx_pkg::token_t head,
    output logic            head_valid,
    output logic            room,
    output tlx_pkg::q_status_t status
);
    import tlx_pkg::*;

    token_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   level_reg, level_next;
    logic [QCNT_BITS-1:0]   n_in;
    logic [QPTR_BITS-1:0]   wr_ptr_plus1;

    assign n_in         = push_en ? QCNT_BITS'(push.count) : '0;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_BITS'(1);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(n_in);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        level_next  = level_reg + n_in - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the new tokens at the tail
    always_ff @(posedge clk)
    begin
        if (n_in != '0)
        begin
            entry_reg[wr_ptr_reg] <= push.tok0;
        end
        if (n_in == QCNT_BITS'(2))
        begin
            entry_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign head_valid   = (level_reg != '0);
    assign room         = (level_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign status.level = level_reg;

endmodule

/* design/tlx_core.sv */
// Lexer state machine: holds mode, offsets and run length, and turns each
// accepted byte into zero, one or two tokens. Depends on tlx_pkg.
module tlx_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     char_code,
    output tlx_pkg::push_t push
);
    import tlx_pkg::*;

    mode_t                     mode_reg, mode_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  begin_reg, begin_next;
    logic                      pending_reg, pending_next;
    logic [LEN_BITS-1:0]       len_reg, len_next;

    logic [LEN_BITS-1:0]       len_g1;
    logic                      run_idle;
    logic                      end_text;
    logic                      tok_a_valid;
    token_t                    tok_a;
    logic                      tok_b_valid;
    token_t                    tok_b;
    tok_kind_t                 sym;

    assign len_g1   = sat_inc(len_reg);
    assign sym      = symbol_kind(char_code);
    assign end_text = run_idle && (char_code == CH_NUL);

    // Decode the first pass: token closed by this byte, and whether the
    // byte falls through to the between-tokens handling
    always_comb
    begin
        run_idle    = 1'b0;
        tok_a_valid = 1'b0;
        tok_a.kind  = TOK_UNKNOWN;
        tok_a.start = FIELD_BITS'(begin_reg);
        tok_a.length = len_reg;
        tok_a.last  = 1'b0;
        case (mode_reg)
            MODE_SLASH:
            begin
                if ((char_code != CH_SLASH) && (char_code != CH_STAR))
                begin
                    tok_a_valid  = 1'b1;
                    tok_a.kind   = TOK_UNKNOWN;
                    tok_a.length = FIELD_BITS'(1);
                    run_idle     = 1'b1;
                end
            end
            MODE_LINE, MODE_BLOCK, MODE_STAR:
            begin
                run_idle = (char_code == CH_NUL);
            end
            MODE_STR:
            begin
                if ((char_code == CH_NUL) || (char_code == CH_QUOTE))
                begin
                    tok_a_valid = 1'b1;
                    tok_a.kind  = TOK_STRING;
                end
                run_idle = (char_code == CH_NUL);
            end
            MODE_ESC:
            begin
                if (char_code == CH_NUL)
                begin
                    tok_a_valid = 1'b1;
                    tok_a.kind  = TOK_STRING;
                    run_idle    = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (!is_ident_char(char_code))
                begin
                    tok_a_valid = 1'b1;
                    tok_a.kind  = TOK_IDENT;
                    run_idle    = 1'b1;
                end
            end
            MODE_NUM:
            begin
                if (pending_reg && is_digit(char_code))
                begin
                    tok_a_valid = 1'b1;
                    tok_a.kind  = TOK_NUMBER;
                end
                else if (!is_digit(char_code) && (char_code != CH_DOT)
                         && !is_alpha(char_code))
                begin
                    tok_a_valid  = 1'b1;
                    tok_a.kind   = TOK_NUMBER;
                    tok_a.length = pending_reg ? len_g1 : len_reg;
                    run_idle     = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase
    end

    // Between-tokens handling: tokens that stand on one byte
    always_comb
    begin
        tok_b_valid  = 1'b0;
        tok_b.kind   = TOK_UNKNOWN;
        tok_b.start  = FIELD_BITS'(pos_reg);
        tok_b.length = FIELD_BITS'(1);
        tok_b.last   = 1'b1;
        if (run_idle)
        begin
            if (char_code == CH_NUL)
            begin
                tok_b_valid = 1'b1;
                tok_b.kind  = TOK_EOF;
            end
            else if (is_space(char_code))
            begin
                tok_b_valid = 1'b0;
            end
            else if (sym != TOK_EOF)
            begin
                tok_b_valid = 1'b1;
                tok_b.kind  = sym;
            end
            else if ((char_code != CH_SLASH) && (char_code != CH_QUOTE)
                     && !is_alpha(char_code) && !is_digit(char_code))
            begin
                tok_b_valid = 1'b1;
                tok_b.kind  = TOK_UNKNOWN;
            end
        end
    end

    // Order the tokens and mark the last one of this byte
    always_comb
    begin
        push.count     = 2'(tok_a_valid) + 2'(tok_b_valid);
        push.tok0      = tok_a_valid ? tok_a : tok_b;
        push.tok0.last = !(tok_a_valid && tok_b_valid);
        push.tok1      = tok_b;
    end

    // Next state
    always_comb
    begin
        mode_next    = mode_reg;
        begin_next   = begin_reg;
        pending_next = pending_reg;
        len_next     = len_reg;
        case (mode_reg)
            MODE_SLASH:
            begin
                if (char_code == CH_SLASH)
                begin
                    mode_next = MODE_LINE;
                end
                else if (char_code == CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_LINE:
            begin
                if (char_code == CH_LF)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BLOCK:
            begin
                if (char_code == CH_STAR)
                begin
                    mode_next = MODE_STAR;
                end
            end
            MODE_STAR:
            begin
                if (char_code == CH_SLASH)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (char_code != CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_STR:
            begin
                if (char_code == CH_QUOTE)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (char_code != CH_NUL)
                begin
                    len_next = len_g1;
                    if (char_code == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                end
            end
            MODE_ESC:
            begin
                if (char_code != CH_NUL)
                begin
                    len_next  = len_g1;
                    mode_next = MODE_STR;
                end
            end
            MODE_IDENT:
            begin
                if (is_ident_char(char_code))
                begin
                    len_next = len_g1;
                end
            end
            MODE_NUM:
            begin
                pending_next = 1'b0;
                if (pending_reg && is_digit(char_code))
                begin
                    // number ends before the letter; identifier starts there
                    mode_next  = MODE_IDENT;
                    begin_next = pos_reg - POSITION_BITS'(1);
                    len_next   = sat_inc(LEN_BITS'(1));
                end
                else
                begin
                    len_next = pending_reg ? len_g1 : len_reg;
                    if (is_digit(char_code) || (char_code == CH_DOT))
                    begin
                        len_next = sat_inc(pending_reg ? len_g1 : len_reg);
                    end
                    else if (is_alpha(char_code))
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Start a token between tokens
        if (run_idle)
        begin
            mode_next = MODE_IDLE;
            if (char_code == CH_SLASH)
            begin
                mode_next  = MODE_SLASH;
                begin_next = pos_reg;
            end
            else if (char_code == CH_QUOTE)
            begin
                mode_next  = MODE_STR;
                begin_next = pos_reg + POSITION_BITS'(1);
                len_next   = '0;
            end
            else if (is_alpha(char_code))
            begin
                mode_next  = MODE_IDENT;
                begin_next = pos_reg;
                len_next   = LEN_BITS'(1);
            end
            else if (is_digit(char_code))
            begin
                mode_next    = MODE_NUM;
                begin_next   = pos_reg;
                len_next     = LEN_BITS'(1);
                pending_next = 1'b0;
            end
        end

        // Advance the offset, or start a new text after end of text
        pos_next = pos_reg + POSITION_BITS'(1);
        if (end_text)
        begin
            mode_next    = MODE_IDLE;
            pos_next     = '0;
            begin_next   = '0;
            pending_next = 1'b0;
            len_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pos_reg     <= '0;
            begin_reg   <= '0;
            pending_reg <= 1'b0;
            len_reg     <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            begin_reg   <= begin_next;
            pending_reg <= pending_next;
            len_reg     <= len_next;
        end
    end

endmodule

/* design/text_lexer.sv */
// Top level of the streaming text lexer: byte stream in, token stream out.
// Depends on tlx_pkg, tlx_core and tlx_queue.
//
//  channel   | dir | tdata fields (low bit up)               | tlast
//  s_*       | in  | char_code[7:0]                           | -
//  m_*       | out | token_type, token_start, token_length    | run_last
//
// One byte is taken per cycle while the queue has room for two tokens; each
// byte yields zero to two tokens, which leave one per cycle while m_tready is
// high, from a four-entry token queue. Input stalls only when the output side
// falls behind. Tokens are registered in the queue and leave in order.
// Reset puts the lexer between tokens at offset 0 and empties the queue.
module text_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // token_type[3:0], token_start[19:4],
                                   // token_length[35:20], zeros[39:36]
    output logic        m_tlast    // run_last
);
    import tlx_pkg::*;

    logic      in_accept;
    logic      out_accept;
    push_t     push;
    token_t    head;
    logic      head_valid;
    logic      room;
    q_status_t q_status;

    assign s_tready   = room;
    assign in_accept  = s_tvalid && room;
    assign out_accept = head_valid && m_tready;

    tlx_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .char_code (s_tdata),
        .push      (push)
    );

    tlx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (in_accept),
        .push       (push),
        .pop        (out_accept),
        .head       (head),
        .head_valid (head_valid),
        .room       (room),
        .status     (q_status)
    );

    // Pack the head token onto the output bus
    assign m_tvalid = head_valid;
    assign m_tdata  = {4'b0000, head.length, head.start, head.kind};
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("token queue overfilled");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (q_status.level <= QCNT_BITS'(QUEUE_DEPTH - 2)))
        else $error("byte taken without room for two tokens");

    a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata == CH_NUL)) |=> m_tvalid)
        else $error("end of text gave no token");

    a_valid_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid == (q_status.level != '0))
        else $error("output valid disagrees with queue level");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking bench for text_lexer: feeds byte streams and checks every token.
// Depends on tlx_pkg (byte codes, mode and token kinds) and the text_lexer RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tlx_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Idle rates of both sides, in percent
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    int unsigned chars_sent     = 0;
    int unsigned tokens_checked = 0;
    int unsigned error_count    = 0;

    // Lexer state mirrored by the predictor
    mode_t                 lx_mode   = MODE_IDLE;
    logic [POSITION_BITS-1:0] lx_pos = '0;
    logic [FIELD_BITS-1:0] lx_begin  = '0;
    logic [LEN_BITS-1:0]   lx_len    = '0;
    logic                  lx_letter = 1'b0;

    token_t byte_tokens[$];
    token_t expected_tokens[$];

    text_lexer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic logic ch_is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic ch_is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic ch_is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // TOK_EOF stands for "not a one-byte symbol"
    function automatic tok_kind_t char_symbol(input logic [7:0] c);
        case (c)
            CH_LPAREN: return TOK_LPAREN;
            CH_RPAREN: return TOK_RPAREN;
            CH_LBRACE: return TOK_LBRACE;
            CH_RBRACE: return TOK_RBRACE;
            CH_LBRACK: return TOK_LBRACK;
            CH_RBRACK: return TOK_RBRACK;
            CH_COLON:  return TOK_COLON;
            CH_SEMI:   return TOK_SEMI;
            CH_STAR:   return TOK_STAR;
            CH_EQUAL:  return TOK_EQUAL;
            default:   return TOK_EOF;
        endcase
    endfunction

    function automatic logic [LEN_BITS-1:0] len_up(input logic [LEN_BITS-1:0] n);
        return (n == LEN_MAX) ? n : n + 1'b1;
    endfunction

    function automatic void add_token(input tok_kind_t k, input logic [FIELD_BITS-1:0] s,
                                      input logic [LEN_BITS-1:0] n);
        token_t t;
        if (byte_tokens.size() < 3)
        begin
            t.kind   = k;
            t.start  = s;
            t.length = n;
            t.last   = 1'b0;
            byte_tokens.push_back(t);
        end
    endfunction

    // Advance the mirrored lexer by one byte and queue the tokens it yields
    function automatic void lex_byte(input logic [7:0] c);
        logic [POSITION_BITS-1:0] p;
        logic      text_done;
        logic      again;
        logic      split;
        tok_kind_t sym;
        p         = lx_pos;
        text_done = 1'b0;
        byte_tokens.delete();
        for (int pass = 0; pass < 3; pass++)
        begin
            again = 1'b0;
            case (lx_mode)
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                        lx_mode = MODE_LINE;
                    else if (c == CH_STAR)
                        lx_mode = MODE_BLOCK;
                    else
                    begin
                        add_token(TOK_UNKNOWN, lx_begin, LEN_BITS'(1));
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (c == CH_NUL)
                    begin
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                    else if (c == CH_LF)
                        lx_mode = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (c == CH_NUL)
                    begin
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                    else if (c == CH_STAR)
                        lx_mode = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (c == CH_NUL)
                    begin
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                    else if (c == CH_SLASH)
                        lx_mode = MODE_IDLE;
                    else if (c != CH_STAR)
                        lx_mode = MODE_BLOCK;
                end
                MODE_STR:
                begin
                    if (c == CH_NUL || c == CH_QUOTE)
                    begin
                        add_token(TOK_STRING, lx_begin, lx_len);
                        lx_mode = MODE_IDLE;
                        again   = (c == CH_NUL);
                    end
                    else
                    begin
                        lx_len = len_up(lx_len);
                        if (c == CH_BSLASH)
                            lx_mode = MODE_ESC;
                    end
                end
                MODE_ESC:
                begin
                    if (c == CH_NUL)
                    begin
                        add_token(TOK_STRING, lx_begin, lx_len);
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                    else
                    begin
                        lx_len  = len_up(lx_len);
                        lx_mode = MODE_STR;
                    end
                end
                MODE_IDENT:
                begin
                    if (ch_is_letter(c) || ch_is_num(c) || c == CH_UNDER || c == CH_DOT)
                        lx_len = len_up(lx_len);
                    else
                    begin
                        add_token(TOK_IDENT, lx_begin, lx_len);
                        lx_mode = MODE_IDLE;
                        again   = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    split = 1'b0;
                    // A held letter followed by a digit starts an identifier
                    if (lx_letter)
                    begin
                        lx_letter = 1'b0;
                        if (ch_is_num(c))
                        begin
                            add_token(TOK_NUMBER, lx_begin, lx_len);
                            lx_mode  = MODE_IDENT;
                            lx_begin = p - 1'b1;
                            lx_len   = LEN_BITS'(1);
                            again    = 1'b1;
                            split    = 1'b1;
                        end
                        else
                            lx_len = len_up(lx_len);
                    end
                    if (!split)
                    begin
                        if (ch_is_num(c) || c == CH_DOT)
                            lx_len = len_up(lx_len);
                        else if (ch_is_letter(c))
                            lx_letter = 1'b1;
                        else
                        begin
                            add_token(TOK_NUMBER, lx_begin, lx_len);
                            lx_mode = MODE_IDLE;
                            again   = 1'b1;
                        end
                    end
                end
                default:
                begin
                    lx_mode = MODE_IDLE;
                    sym     = char_symbol(c);
                    if (c == CH_NUL)
                    begin
                        add_token(TOK_EOF, p, LEN_BITS'(1));
                        text_done = 1'b1;
                    end
                    else if (ch_is_blank(c))
                        ;
                    else if (sym != TOK_EOF)
                        add_token(sym, p, LEN_BITS'(1));
                    else if (c == CH_SLASH)
                    begin
                        lx_mode  = MODE_SLASH;
                        lx_begin = p;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        lx_mode  = MODE_STR;
                        lx_begin = p + 1'b1;
                        lx_len   = '0;
                    end
                    else if (ch_is_letter(c))
                    begin
                        lx_mode  = MODE_IDENT;
                        lx_begin = p;
                        lx_len   = LEN_BITS'(1);
                    end
                    else if (ch_is_num(c))
                    begin
                        lx_mode   = MODE_NUM;
                        lx_begin  = p;
                        lx_len    = LEN_BITS'(1);
                        lx_letter = 1'b0;
                    end
                    else
                        add_token(TOK_UNKNOWN, p, LEN_BITS'(1));
                end
            endcase
            if (!again)
                break;
        end

        // Mark the final token of this byte and hand all over to the checker
        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i])
            expected_tokens.push_back(byte_tokens[i]);

        // End of text restarts the lexer at offset 0
        if (text_done)
        begin
            lx_mode   = MODE_IDLE;
            lx_pos    = '0;
            lx_begin  = '0;
            lx_letter = 1'b0;
            lx_len    = '0;
        end
        else
            lx_pos = p + 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Byte source
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lex_byte(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // ---------------------------------------------------------------
    // Token sink and checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        token_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (m_tvalid && m_tready)
            begin
                tokens_checked++;
                if (expected_tokens.size() == 0)
                begin
                    error_count++;
                    $display("%0t: expected no token, got kind=%0d start=%0d len=%0d last=%0b",
                             $time, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (m_tdata[3:0] !== want.kind || m_tdata[19:4] !== want.start ||
                        m_tdata[35:20] !== want.length || m_tlast !== want.last)
                    begin
                        error_count++;
                        $display("%0t: token mismatch, expected kind=%0d start=%0d len=%0d last=%0b,",
                                 $time, want.kind, want.start, want.length, want.last);
                        $display("    got kind=%0d start=%0d len=%0d last=%0b",
                                 m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // All ten symbols and the four blanks
    task automatic test_symbols();
        send_text("(){}[]:;*= \t\r\n");
    endtask

    // Lone slash, unknown top byte, end of text inside a block comment
    task automatic test_comments();
        send_text("/a/");
        send_char(8'hFF);
        send_text("/*");
        send_char(CH_NUL);
    endtask

    // Letter in a number: split before the letter when a digit follows, kept otherwise
    task automatic test_numbers();
        send_text("1e5 2x;");
    endtask

    // Escaped quote, then end of text right after a backslash
    task automatic test_strings();
        send_text("\"\\\"\\");
        send_char(CH_NUL);
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25))
                                           : 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_ident_char();
        case ($urandom_range(0, 5))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return CH_UNDER;
            2:       return CH_DOT;
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_symbol();
        case ($urandom_range(0, 9))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_LBRACK;
            5:       return CH_RBRACK;
            6:       return CH_COLON;
            7:       return CH_SEMI;
            8:       return CH_STAR;
            default: return CH_EQUAL;
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Send one random lexeme, mostly well formed, sometimes broken or noise
    task automatic send_fragment();
        int unsigned n;
        logic [7:0]  c;
        n = $urandom_range(1, 6);
        case ($urandom_range(0, 19))
            0, 1, 2:
                send_char(rand_symbol());
            3, 4, 5:
                send_char(rand_blank());
            6, 7, 8:
            begin
                send_char(rand_letter());
                repeat (n - 1)
                    send_char(rand_ident_char());
            end
            9, 10, 11:
            begin
                send_char(8'("0" + $urandom_range(0, 9)));
                repeat (n - 1)
                begin
                    case ($urandom_range(0, 3))
                        0:       send_char(CH_DOT);
                        1:       send_char(rand_letter());
                        default: send_char(8'("0" + $urandom_range(0, 9)));
                    endcase
                end
            end
            12, 13:
            begin
                send_char(CH_QUOTE);
                repeat (n)
                begin
                    c = 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 4) == 0)
                        send_char(CH_BSLASH);
                    else if (c == CH_QUOTE || c == CH_BSLASH)
                        c = "q";
                    send_char(c);
                end
                // Leave some strings open
                if ($urandom_range(0, 7) != 0)
                    send_char(CH_QUOTE);
            end
            14:
            begin
                send_text("//");
                repeat (n)
                begin
                    c = 8'($urandom_range(1, 255));
                    send_char(c == CH_LF ? CH_SPACE : c);
                end
                send_char(CH_LF);
            end
            15:
            begin
                send_text("/*");
                repeat (n)
                    send_char(($urandom_range(0, 3) == 0) ? CH_STAR
                                                          : 8'($urandom_range(1, 255)));
                send_text("*/");
            end
            16:
            begin
                send_char(CH_SLASH);
                send_char(8'($urandom_range(0, 255)));
            end
            17, 18:
                send_char(8'($urandom_range(0, 255)));
            default:
                send_char(CH_NUL);
        endcase
    endtask

    task automatic test_random_text(input int unsigned target);
        while (chars_sent < target)
            send_fragment();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 26;
        snk_idle_pct = 50;
        test_symbols();
        test_comments();
        test_numbers();
        test_strings();
        test_random_text(90);

        src_idle_pct = 50;
        snk_idle_pct = 26;
        test_random_text(170);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_text(250);
        s_tvalid <= 1'b0;

        // Drain the token queue
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes and checked %0d tokens: symbols, blanks, comments,",
                 chars_sent, tokens_checked);
        $display("strings with escapes, split numbers and EOF restarts under back-pressure.");
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
